@@ rtl/tlnf_pkg.sv @@
package tlnf_pkg;

    // default width of the line number in decimal digits
    localparam int NUMBER_DIGITS_DEF = 6;

    // depth of the job queue between front and back
    localparam int JOBQ_DEPTH = 2;

    // configuration address width and register indexes
    localparam int CFG_ADDR_W = 5;
    localparam logic [2:0] REG_NUMBER_MODE      = 3'd0;
    localparam logic [2:0] REG_SQUEEZE_BLANK    = 3'd1;
    localparam logic [2:0] REG_SHOW_ENDS        = 3'd2;
    localparam logic [2:0] REG_SHOW_TABS        = 3'd3;
    localparam logic [2:0] REG_SHOW_NONPRINTING = 3'd4;

    // numbering modes
    localparam logic [1:0] NUM_OFF      = 2'd0;
    localparam logic [1:0] NUM_ALL      = 2'd1;
    localparam logic [1:0] NUM_NONBLANK = 2'd2;

    // character codes
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_DOLLAR   = 8'h24;
    localparam logic [7:0] CH_DASH     = 8'h2D;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_QMARK    = 8'h3F;
    localparam logic [7:0] CH_I        = 8'h49;
    localparam logic [7:0] CH_M        = 8'h4D;
    localparam logic [7:0] CH_CARET    = 8'h5E;
    localparam logic [7:0] CH_DEL      = 8'h7F;
    localparam logic [7:0] CTRL_LIMIT  = 8'h20;
    localparam logic [7:0] CTRL_OFFSET = 8'h40;

    // configuration register set
    typedef struct packed {
        logic [1:0] number_mode;
        logic       squeeze_blank;
        logic       show_ends;
        logic       show_tabs;
        logic       show_nonprinting;
    } cfg_t;

    // one classified item: optional number, then one to four tail bytes
    typedef struct packed {
        logic            num;
        logic [1:0]      tail_last;
        logic [3:0][7:0] tail;
    } job_t;

endpackage

@@ rtl/tlnf_jobq.sv @@
module tlnf_jobq #(
    parameter int WIDTH = 8,
    parameter int DEPTH = tlnf_pkg::JOBQ_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign valid   = (count_reg != '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && valid;
    assign rd_data = slot_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("job queue count out of range");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty job queue with unequal pointers");

    a_wr_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("job queue count missed a write");

endmodule

@@ rtl/tlnf_front.sv @@
module tlnf_front #(
    parameter int NUMBER_DIGITS = tlnf_pkg::NUMBER_DIGITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tlnf_pkg::cfg_t               cfg,
    input  logic                         push,
    output logic                         full,
    input  logic [7:0]                   in_byte,
    input  logic                         first_of_file,
    input  logic                         q_full,
    output logic                         q_push,
    output tlnf_pkg::job_t               q_job,
    output logic [4*NUMBER_DIGITS-1:0]   q_count
);

    localparam int CW = 4 * NUMBER_DIGITS;

    logic [CW-1:0] count_reg;
    logic          als_reg;
    logic [1:0]    br_reg;

    logic          accept;
    logic          als_eff;
    logic [1:0]    br_eff;
    logic [1:0]    br_new;
    logic          squeezed;
    logic          num;
    logic          als_next;
    logic [CW-1:0] count_inc;
    logic          all_nines;
    logic          carry;
    logic [3:0]    dig;
    logic          hi;
    logic [7:0]    c7;
    logic          ctrl;
    logic          del;
    logic [7:0]    fin;
    logic          special;

    assign full    = q_full;
    assign accept  = push && !q_full;
    assign q_push  = accept && !squeezed;
    assign q_count = count_reg;

    // blank-run tracking and numbering decision
    always_comb
    begin
        als_eff  = first_of_file | als_reg;
        br_eff   = first_of_file ? 2'd0 : br_reg;
        br_new   = br_eff;
        squeezed = 1'b0;
        if (cfg.squeeze_blank)
        begin
            if (als_eff && in_byte == tlnf_pkg::CH_LF)
            begin
                br_new = (br_eff > 2'd1) ? 2'd2 : br_eff + 2'd1;
            end
            else
            begin
                br_new = 2'd0;
            end
            squeezed = (br_new > 2'd1);
        end
        num = als_eff && (cfg.number_mode == tlnf_pkg::NUM_ALL ||
              (cfg.number_mode == tlnf_pkg::NUM_NONBLANK && in_byte != tlnf_pkg::CH_LF));
        if (cfg.show_tabs && in_byte == tlnf_pkg::CH_TAB)
        begin
            als_next = 1'b0;
        end
        else
        begin
            als_next = (in_byte == tlnf_pkg::CH_LF);
        end
    end

    // saturating bcd increment
    always_comb
    begin
        all_nines = 1'b1;
        carry     = 1'b1;
        count_inc = count_reg;
        for (int i = 0; i < NUMBER_DIGITS; i++)
        begin
            dig = count_reg[4*i +: 4];
            if (dig != 4'd9)
            begin
                all_nines = 1'b0;
            end
            if (carry)
            begin
                if (dig >= 4'd9)
                begin
                    count_inc[4*i +: 4] = 4'd0;
                end
                else
                begin
                    count_inc[4*i +: 4] = dig + 4'd1;
                    carry = 1'b0;
                end
            end
        end
        if (all_nines)
        begin
            count_inc = count_reg;
        end
    end

    // tail bytes after the optional number
    always_comb
    begin
        hi      = in_byte[7];
        c7      = {1'b0, in_byte[6:0]};
        ctrl    = (c7 < tlnf_pkg::CTRL_LIMIT);
        del     = (c7 == tlnf_pkg::CH_DEL);
        fin     = ctrl ? c7 + tlnf_pkg::CTRL_OFFSET : (del ? tlnf_pkg::CH_QMARK : c7);
        special = cfg.show_nonprinting && in_byte != tlnf_pkg::CH_CR &&
                  in_byte != tlnf_pkg::CH_LF && in_byte != tlnf_pkg::CH_TAB;
        q_job.num       = num;
        q_job.tail      = '0;
        q_job.tail_last = 2'd0;
        if (cfg.show_tabs && in_byte == tlnf_pkg::CH_TAB)
        begin
            q_job.tail[0]   = tlnf_pkg::CH_CARET;
            q_job.tail[1]   = tlnf_pkg::CH_I;
            q_job.tail_last = 2'd1;
        end
        else if (cfg.show_ends && in_byte == tlnf_pkg::CH_LF)
        begin
            q_job.tail[0]   = tlnf_pkg::CH_DOLLAR;
            q_job.tail[1]   = tlnf_pkg::CH_LF;
            q_job.tail_last = 2'd1;
        end
        else if (special)
        begin
            case ({hi, ctrl || del})
                2'b11:
                begin
                    q_job.tail[0]   = tlnf_pkg::CH_M;
                    q_job.tail[1]   = tlnf_pkg::CH_DASH;
                    q_job.tail[2]   = tlnf_pkg::CH_CARET;
                    q_job.tail[3]   = fin;
                    q_job.tail_last = 2'd3;
                end
                2'b10:
                begin
                    q_job.tail[0]   = tlnf_pkg::CH_M;
                    q_job.tail[1]   = tlnf_pkg::CH_DASH;
                    q_job.tail[2]   = fin;
                    q_job.tail_last = 2'd2;
                end
                2'b01:
                begin
                    q_job.tail[0]   = tlnf_pkg::CH_CARET;
                    q_job.tail[1]   = fin;
                    q_job.tail_last = 2'd1;
                end
                default:
                begin
                    q_job.tail[0]   = fin;
                    q_job.tail_last = 2'd0;
                end
            endcase
        end
        else
        begin
            q_job.tail[0] = in_byte;
        end
    end

    // line state update on each accepted transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CW'(1);
            als_reg   <= 1'b1;
            br_reg    <= 2'd0;
        end
        else if (accept)
        begin
            br_reg <= br_new;
            if (squeezed)
            begin
                als_reg <= als_eff;
            end
            else
            begin
                als_reg <= als_next;
                if (num)
                begin
                    count_reg <= count_inc;
                end
            end
        end
    end

endmodule

@@ rtl/tlnf_back.sv @@
module tlnf_back #(
    parameter int NUMBER_DIGITS = tlnf_pkg::NUMBER_DIGITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    input  tlnf_pkg::job_t               q_job,
    input  logic [4*NUMBER_DIGITS-1:0]   q_count,
    output logic                         q_pop,
    output logic [7:0]                   out_byte,
    output logic                         last_of_run,
    output logic                         empty,
    input  logic                         pop
);

    localparam int IDX_W = $clog2(NUMBER_DIGITS + 1);

    logic [IDX_W-1:0] idx_reg;
    logic             num_done_reg;
    logic [1:0]       tail_idx_reg;
    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             out_last_reg;

    logic             adv;
    logic             num_phase;
    logic [7:0]       byte_c;
    logic             last_c;
    logic             zero_acc;
    logic [3:0]       dig;
    logic [3:0]       dig_sel;
    logic             lead_sel;

    assign empty       = !out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = out_last_reg;
    assign adv         = q_valid && (!out_valid_reg || pop);
    assign num_phase   = q_job.num && !num_done_reg;
    assign q_pop       = adv && !num_phase && last_c;

    // digit under the cursor and its leading-zero blanking
    always_comb
    begin
        zero_acc = 1'b1;
        dig_sel  = 4'd0;
        lead_sel = 1'b0;
        for (int i = NUMBER_DIGITS - 1; i >= 0; i--)
        begin
            dig = q_count[4*i +: 4];
            if (dig > 4'd9)
            begin
                dig = 4'd9;
            end
            zero_acc = zero_acc && (dig == 4'd0);
            if (idx_reg == IDX_W'(NUMBER_DIGITS - 1 - i))
            begin
                dig_sel  = dig;
                lead_sel = zero_acc && (i != 0);
            end
        end
    end

    // next output byte
    always_comb
    begin
        if (num_phase)
        begin
            last_c = 1'b0;
            if (idx_reg == IDX_W'(NUMBER_DIGITS))
            begin
                byte_c = tlnf_pkg::CH_TAB;
            end
            else if (lead_sel)
            begin
                byte_c = tlnf_pkg::CH_SPACE;
            end
            else
            begin
                byte_c = tlnf_pkg::CH_ZERO + {4'd0, dig_sel};
            end
        end
        else
        begin
            byte_c = q_job.tail[tail_idx_reg];
            last_c = (tail_idx_reg == q_job.tail_last);
        end
    end

    // sequencer over number and tail bytes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            num_done_reg  <= 1'b0;
            tail_idx_reg  <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                out_valid_reg <= 1'b1;
                if (num_phase)
                begin
                    if (idx_reg == IDX_W'(NUMBER_DIGITS))
                    begin
                        idx_reg      <= '0;
                        num_done_reg <= 1'b1;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                else if (last_c)
                begin
                    num_done_reg <= 1'b0;
                    tail_idx_reg <= 2'd0;
                end
                else
                begin
                    tail_idx_reg <= tail_idx_reg + 2'd1;
                end
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_byte_reg <= byte_c;
            out_last_reg <= last_c;
        end
    end

    a_num_done_job: assert property (@(posedge clk) disable iff (!rst_n)
        num_done_reg |-> (q_valid && q_job.num))
        else $error("number marked done without a numbered job");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= IDX_W'(NUMBER_DIGITS))
        else $error("digit cursor out of range");

    a_tail_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (tail_idx_reg != 2'd0) |-> (q_valid && tail_idx_reg <= q_job.tail_last))
        else $error("tail cursor beyond job");

endmodule

@@ rtl/text_line_number_and_visible_filter_core.sv @@
// Line numbering and visible-character text filter.
// Input channel: one text byte per transfer on in_byte, with first_of_file
// marking the first byte of a new file (line-start and blank-run state reset,
// line count kept). A transfer happens when push is high and full is low.
// Result channel: each input byte yields one to 11 output bytes on out_byte,
// with last_of_run set on the final one; none for a squeezed empty line. The
// oldest result is shown while empty is low and taken when pop is high.
// Configuration: APB-style registers at byte addresses 0, 4, 8, 12, 16 for
// number_mode, squeeze_blank, show_ends, show_tabs, show_nonprinting; write
// only while the block is idle. pready is tied high.
// Flow: an item's results pass the job queue, then the output register.
// The front classifies one item per cycle while the job queue has room;
// the back emits one output byte per cycle while a job waits and the
// output is empty or popped. A two-entry job queue separates them.
// Reset: registers read zero, line count is one, the block starts at the
// start of a line. When pop stays low the output byte holds, the job queue
// fills and full rises; nothing is lost.
module text_line_number_and_visible_filter_core #(
    parameter int NUMBER_DIGITS = tlnf_pkg::NUMBER_DIGITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tlnf_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  logic                            push,
    output logic                            full,
    input  logic [7:0]                      in_byte,
    input  logic                            first_of_file,
    output logic                            empty,
    input  logic                            pop,
    output logic [7:0]                      out_byte,
    output logic                            last_of_run
);

    localparam int CW    = 4 * NUMBER_DIGITS;
    localparam int JOB_W = $bits(tlnf_pkg::job_t);
    localparam int Q_W   = JOB_W + CW;

    tlnf_pkg::cfg_t   cfg_reg;
    logic             cfg_wr;
    logic [2:0]       reg_idx;

    logic             jq_full;
    logic             jq_push;
    tlnf_pkg::job_t   f_job;
    logic [CW-1:0]    f_count;
    logic [Q_W-1:0]   jq_rd;
    logic             jq_valid;
    logic             jq_pop;
    tlnf_pkg::job_t   b_job;
    logic [CW-1:0]    b_count;

    assign pready  = 1'b1;
    assign reg_idx = paddr[tlnf_pkg::CFG_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                tlnf_pkg::REG_NUMBER_MODE:      cfg_reg.number_mode      <= pwdata[1:0];
                tlnf_pkg::REG_SQUEEZE_BLANK:    cfg_reg.squeeze_blank    <= pwdata[0];
                tlnf_pkg::REG_SHOW_ENDS:        cfg_reg.show_ends        <= pwdata[0];
                tlnf_pkg::REG_SHOW_TABS:        cfg_reg.show_tabs        <= pwdata[0];
                tlnf_pkg::REG_SHOW_NONPRINTING: cfg_reg.show_nonprinting <= pwdata[0];
                default:                        cfg_reg <= cfg_reg;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (reg_idx)
            tlnf_pkg::REG_NUMBER_MODE:      prdata = {30'd0, cfg_reg.number_mode};
            tlnf_pkg::REG_SQUEEZE_BLANK:    prdata = {31'd0, cfg_reg.squeeze_blank};
            tlnf_pkg::REG_SHOW_ENDS:        prdata = {31'd0, cfg_reg.show_ends};
            tlnf_pkg::REG_SHOW_TABS:        prdata = {31'd0, cfg_reg.show_tabs};
            tlnf_pkg::REG_SHOW_NONPRINTING: prdata = {31'd0, cfg_reg.show_nonprinting};
            default:                        prdata = 32'd0;
        endcase
    end

    // front: accept and classify
    tlnf_front #(
        .NUMBER_DIGITS (NUMBER_DIGITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .push          (push),
        .full          (full),
        .in_byte       (in_byte),
        .first_of_file (first_of_file),
        .q_full        (jq_full),
        .q_push        (jq_push),
        .q_job         (f_job),
        .q_count       (f_count)
    );

    // job queue
    tlnf_jobq #(
        .WIDTH (Q_W),
        .DEPTH (tlnf_pkg::JOBQ_DEPTH)
    ) u_jobq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (jq_push),
        .wr_data ({f_job, f_count}),
        .full    (jq_full),
        .rd_en   (jq_pop),
        .rd_data (jq_rd),
        .valid   (jq_valid)
    );

    assign b_job   = jq_rd[Q_W-1:CW];
    assign b_count = jq_rd[CW-1:0];

    // back: emit output bytes
    tlnf_back #(
        .NUMBER_DIGITS (NUMBER_DIGITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (jq_valid),
        .q_job       (b_job),
        .q_count     (b_count),
        .q_pop       (jq_pop),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .empty       (empty),
        .pop         (pop)
    );

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    localparam int DIGITS       = tlnf_pkg::NUMBER_DIGITS_DEF;
    localparam int BCD_W        = 4 * DIGITS;
    localparam int HALF_PERIOD  = 10;
    localparam int DRAIN_CYCLES = 12;
    localparam int LONG_HOLD    = 300;
    localparam int STALL_LIMIT  = 2000;
    localparam int BULK_LINES   = 100;
    localparam int PHASE_ITEMS  = 18;

    typedef struct packed {
        logic [7:0] ch;
        logic       fof;
    } text_item_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } out_item_t;

    // block ports
    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [tlnf_pkg::CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0]                     pwdata = '0;
    logic [31:0]                     prdata;
    logic                            pready;
    logic                            push = 1'b0;
    logic                            full;
    logic [7:0]                      in_byte = '0;
    logic                            first_of_file = 1'b0;
    logic                            empty;
    logic                            pop = 1'b0;
    logic [7:0]                      out_byte;
    logic                            last_of_run;

    // text bytes waiting to be sent, formatted bytes waiting to come out
    text_item_t text_q[$];
    out_item_t  formatted_q[$];

    // predicted block state
    tlnf_pkg::cfg_t   mode_cfg = '0;
    logic [BCD_W-1:0] line_bcd = BCD_W'(1);
    logic             at_bol = 1'b1;
    logic [1:0]       blank_lines = 2'd0;
    logic [7:0]       run_bytes[0:15];
    int               run_len;

    int error_count = 0;
    int stall_cycles = 0;
    bit in_taken = 1'b0;
    int hold_requests = 0;
    int hold_served = 0;

    text_line_number_and_visible_filter_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .push          (push),
        .full          (full),
        .in_byte       (in_byte),
        .first_of_file (first_of_file),
        .empty         (empty),
        .pop           (pop),
        .out_byte      (out_byte),
        .last_of_run   (last_of_run)
    );

    always #HALF_PERIOD clk = ~clk;

    task automatic report_error(input string msg);
        if (error_count < 40)
            $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic void put_out(input logic [7:0] b);
        run_bytes[run_len] = b;
        run_len++;
    endfunction

    // move the bytes of one run into the result store, last one flagged
    function automatic void push_run();
        out_item_t item;
        for (int i = 0; i < run_len; i++)
        begin
            item.ch = run_bytes[i];
            item.last = (i == run_len - 1);
            formatted_q.push_back(item);
        end
    endfunction

    // formatting of one text byte into its output run
    function automatic void format_text_byte(input logic [7:0] raw, input logic fof);
        logic [7:0] ch;
        logic [3:0] d;
        logic       leading;
        logic       all_nines;
        logic       carry;
        ch = raw;
        run_len = 0;
        if (fof)
        begin
            at_bol = 1'b1;
            blank_lines = 2'd0;
        end

        // blank line squeezing
        if (mode_cfg.squeeze_blank)
        begin
            if (at_bol && ch == tlnf_pkg::CH_LF)
            begin
                if (blank_lines < 2'd2)
                    blank_lines++;
            end
            else
                blank_lines = 2'd0;
            if (blank_lines > 2'd1)
                return;
        end

        // line number, right aligned, then tab
        if (at_bol && (mode_cfg.number_mode == tlnf_pkg::NUM_ALL ||
                       (mode_cfg.number_mode == tlnf_pkg::NUM_NONBLANK &&
                        ch != tlnf_pkg::CH_LF)))
        begin
            leading = 1'b1;
            for (int i = DIGITS - 1; i >= 0; i--)
            begin
                d = line_bcd[4*i +: 4];
                if (d > 4'd9)
                    d = 4'd9;
                if (d != 4'd0 || i == 0)
                    leading = 1'b0;
                put_out(leading ? tlnf_pkg::CH_SPACE : tlnf_pkg::CH_ZERO + 8'(d));
            end
            put_out(tlnf_pkg::CH_TAB);
            all_nines = 1'b1;
            for (int i = 0; i < DIGITS; i++)
                if (line_bcd[4*i +: 4] != 4'd9)
                    all_nines = 1'b0;
            carry = !all_nines;
            for (int i = 0; i < DIGITS && carry; i++)
            begin
                if (line_bcd[4*i +: 4] >= 4'd9)
                    line_bcd[4*i +: 4] = 4'd0;
                else
                begin
                    line_bcd[4*i +: 4] = line_bcd[4*i +: 4] + 4'd1;
                    carry = 1'b0;
                end
            end
        end

        // visible tab
        if (mode_cfg.show_tabs && ch == tlnf_pkg::CH_TAB)
        begin
            put_out(tlnf_pkg::CH_CARET);
            put_out(tlnf_pkg::CH_I);
            at_bol = 1'b0;
            push_run();
            return;
        end

        if (mode_cfg.show_ends && ch == tlnf_pkg::CH_LF)
            put_out(tlnf_pkg::CH_DOLLAR);

        // caret and meta notation
        if (mode_cfg.show_nonprinting && ch != tlnf_pkg::CH_CR &&
            ch != tlnf_pkg::CH_LF && ch != tlnf_pkg::CH_TAB)
        begin
            if (ch[7])
            begin
                put_out(tlnf_pkg::CH_M);
                put_out(tlnf_pkg::CH_DASH);
                ch[7] = 1'b0;
            end
            if (ch < tlnf_pkg::CTRL_LIMIT)
            begin
                put_out(tlnf_pkg::CH_CARET);
                ch = ch + tlnf_pkg::CTRL_OFFSET;
            end
            else if (ch == tlnf_pkg::CH_DEL)
            begin
                put_out(tlnf_pkg::CH_CARET);
                ch = tlnf_pkg::CH_QMARK;
            end
        end

        put_out(ch);
        at_bol = (ch == tlnf_pkg::CH_LF);
        push_run();
    endfunction

    // input and result transfers, prediction, checking and watchdog
    always @(posedge clk)
    begin : monitor_proc
        bit        out_taken;
        out_item_t want;
        in_taken = rst_n && push && !full;
        out_taken = rst_n && pop && !empty;
        if (in_taken)
            format_text_byte(in_byte, first_of_file);
        if (out_taken)
        begin
            if (formatted_q.size() == 0)
                report_error($sformatf("unexpected out_byte %h last_of_run %b",
                                       out_byte, last_of_run));
            else
            begin
                want = formatted_q.pop_front();
                if (out_byte !== want.ch)
                    report_error($sformatf("out_byte %h, predicted %h", out_byte, want.ch));
                if (last_of_run !== want.last)
                    report_error($sformatf("last_of_run %b, predicted %b on byte %h",
                                           last_of_run, want.last, want.ch));
            end
        end
        if (in_taken || out_taken || psel)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("text_line_number_and_visible_filter_core: mismatch");
            $finish;
        end
    end

    // sender: bursts of transfers with random gaps
    int burst_left = 0;
    int gap_left = 0;

    always @(negedge clk)
    begin : sender_proc
        logic       nxt_push;
        text_item_t nxt;
        nxt_push = push;
        nxt.ch = in_byte;
        nxt.fof = first_of_file;
        if (!rst_n)
            nxt_push = 1'b0;
        else if (!push || in_taken)
        begin
            nxt_push = 1'b0;
            if (gap_left > 0)
                gap_left--;
            else if (text_q.size() > 0)
            begin
                nxt = text_q.pop_front();
                nxt_push = 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
        push <= nxt_push;
        in_byte <= nxt.ch;
        first_of_file <= nxt.fof;
    end

    // receiver: stall pattern of its own, plus requested long hold-offs
    int          hold_left = 0;
    int          pat_left = 0;
    logic [31:0] pop_pat = '1;

    always @(negedge clk)
    begin : receiver_proc
        if (hold_served != hold_requests)
        begin
            hold_served++;
            hold_left = LONG_HOLD;
        end
        if (!rst_n)
            pop <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else
        begin
            if (pat_left == 0)
            begin
                pat_left = 32;
                case ($urandom_range(0, 3))
                    0: pop_pat = '1;
                    1: pop_pat = $urandom();
                    2: pop_pat = $urandom() | $urandom();
                    default: pop_pat = $urandom() & $urandom();
                endcase
            end
            pat_left--;
            pop <= pop_pat[pat_left];
        end
    end

    // wait until the block has nothing left to do
    task automatic drain_block();
        while (text_q.size() != 0 || push || formatted_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // register write, then read back
    task automatic write_register(input logic [2:0] idx, input logic [31:0] val);
        logic [31:0] got;
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        got = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (got !== val)
            report_error($sformatf("register %0d reads %h, written %h", idx, got, val));
    endtask

    task automatic apply_settings(input tlnf_pkg::cfg_t c);
        drain_block();
        write_register(tlnf_pkg::REG_NUMBER_MODE, 32'(c.number_mode));
        write_register(tlnf_pkg::REG_SQUEEZE_BLANK, 32'(c.squeeze_blank));
        write_register(tlnf_pkg::REG_SHOW_ENDS, 32'(c.show_ends));
        write_register(tlnf_pkg::REG_SHOW_TABS, 32'(c.show_tabs));
        write_register(tlnf_pkg::REG_SHOW_NONPRINTING, 32'(c.show_nonprinting));
        mode_cfg = c;
    endtask

    task automatic send_byte(input logic [7:0] ch, input logic fof);
        text_item_t item;
        item.ch = ch;
        item.fof = fof;
        text_q.push_back(item);
    endtask

    function automatic logic [7:0] pick_line_byte();
        case ($urandom_range(0, 19))
            14, 15: return tlnf_pkg::CH_TAB;
            16: return tlnf_pkg::CH_CR;
            17: return 8'($urandom_range(0, 31));
            18: return 8'($urandom_range(128, 255));
            19: return tlnf_pkg::CH_DEL;
            default: return 8'($urandom_range(32, 126));
        endcase
    endfunction

    // mostly whole lines and blank-line runs, some raw noise
    task automatic queue_lines(input int count);
        int added;
        int len;
        added = 0;
        while (added < count)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_byte(8'($urandom()), 1'($urandom_range(0, 1)));
                added++;
            end
            else
            begin
                len = $urandom_range(0, 10);
                for (int i = 0; i < len; i++)
                    send_byte(pick_line_byte(), i == 0 && $urandom_range(0, 11) == 0);
                send_byte(tlnf_pkg::CH_LF, len == 0 && $urandom_range(0, 11) == 0);
                added += len + 1;
                if ($urandom_range(0, 3) == 0)
                begin
                    len = $urandom_range(1, 3);
                    repeat (len) send_byte(tlnf_pkg::CH_LF, 1'b0);
                    added += len;
                end
            end
        end
    endtask

    tlnf_pkg::cfg_t plan[8];

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // reset settings: plain pass-through
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(tlnf_pkg::CH_TAB, 1'b0);
        send_byte(tlnf_pkg::CH_LF, 1'b0);

        // every option on
        apply_settings('{tlnf_pkg::NUM_ALL, 1'b1, 1'b1, 1'b1, 1'b1});
        send_byte(8'h61, 1'b1);
        send_byte(tlnf_pkg::CH_TAB, 1'b0);
        send_byte(tlnf_pkg::CH_LF, 1'b0);
        send_byte(tlnf_pkg::CH_LF, 1'b0);
        send_byte(tlnf_pkg::CH_LF, 1'b0);
        send_byte(tlnf_pkg::CH_LF, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h9F, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(tlnf_pkg::CH_DEL, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(tlnf_pkg::CH_CR, 1'b0);
        send_byte(8'hA0, 1'b0);
        send_byte(8'h8A, 1'b0);
        send_byte(tlnf_pkg::CH_LF, 1'b0);

        // numbering of non-blank lines only
        apply_settings('{tlnf_pkg::NUM_NONBLANK, 1'b0, 1'b0, 1'b0, 1'b0});
        send_byte(tlnf_pkg::CH_LF, 1'b0);
        send_byte(8'h62, 1'b0);
        send_byte(tlnf_pkg::CH_TAB, 1'b0);
        send_byte(tlnf_pkg::CH_LF, 1'b0);

        // number mode three behaves as no numbering
        apply_settings('{2'd3, 1'b0, 1'b0, 1'b0, 1'b0});
        send_byte(8'h63, 1'b0);
        send_byte(tlnf_pkg::CH_LF, 1'b0);

        plan[0] = '{tlnf_pkg::NUM_OFF, 1'b0, 1'b0, 1'b0, 1'b0};
        plan[1] = '{tlnf_pkg::NUM_NONBLANK, 1'b1, 1'b1, 1'b1, 1'b1};
        plan[2] = '{tlnf_pkg::NUM_ALL, 1'b1, 1'b0, 1'b1, 1'b0};
        for (int p = 3; p < 8; p++)
            plan[p] = '{2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1))};

        for (int p = 0; p < 8; p++)
        begin
            // run of numbered lines carries the count into three digits
            if (p == 2)
            begin
                apply_settings('{tlnf_pkg::NUM_ALL, 1'b0, 1'b0, 1'b0, 1'b0});
                repeat (BULK_LINES) send_byte(tlnf_pkg::CH_LF, 1'b0);
            end
            apply_settings(plan[p]);
            if (p == 3)
                hold_requests++;
            queue_lines(PHASE_ITEMS);
        end

        drain_block();
        if (error_count == 0)
            $display("text_line_number_and_visible_filter_core: match");
        else
            $display("text_line_number_and_visible_filter_core: mismatch");
        $finish;
    end

endmodule
